// File: hdl/stepper_angle_positioner_top_defines.svh
// Assertion macros used by the checker file of the stepper angle positioner.
`ifndef STEPPER_ANGLE_POSITIONER_TOP_DEFINES_SVH
`define STEPPER_ANGLE_POSITIONER_TOP_DEFINES_SVH

// Clocked on clk_i and switched off while rst_ni is low.
`define SAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i and also checked while reset is asserted.
`define SAP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/sap_pkg.sv
`default_nettype none
package sap_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned AngleW = 9;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned HoldW  = 11;
  localparam int unsigned MaskW  = 4;

  localparam logic [HoldW-1:0]  HoldBase  = 11'd1250;
  localparam logic [AngleW-1:0] FullTurn  = 9'd360;
  localparam logic [AngleW-1:0] HalfTurn  = 9'd180;
  // Angles are doubled so that one step of 7.5 degrees is a whole 15.
  localparam logic [AngleW-1:0] StepDbl   = 9'd15;
  localparam logic [AngleW-1:0] LastLimit = 9'd30;

  localparam logic [KindW-1:0] KindMove = 2'd0;
  localparam logic [KindW-1:0] KindUp   = 2'd1;
  localparam logic [KindW-1:0] KindDown = 2'd2;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StCalc = 4'b0010,
    StDiv  = 4'b0100,
    StStep = 4'b1000
  } state_e;

  typedef struct packed {
    logic cap;
    logic calc;
    logic emit;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_step;
    logic last_step;
    logic is_move;
    logic slot_free;
  } dp_sts_t;

  function automatic logic [MaskW-1:0] up_mask(input logic [1:0] ph);
    logic [MaskW-1:0] m;
    case (ph)
      2'd0:    m = 4'h3;
      2'd1:    m = 4'h6;
      2'd2:    m = 4'hC;
      default: m = 4'h9;
    endcase
    return m;
  endfunction

  function automatic logic [MaskW-1:0] down_mask(input logic [1:0] ph);
    logic [MaskW-1:0] m;
    case (ph)
      2'd0:    m = 4'h9;
      2'd1:    m = 4'hC;
      2'd2:    m = 4'h6;
      default: m = 4'h3;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sap_div.sv
`default_nettype none
module sap_div import sap_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SpeedW-1:0] divisor_i,
  output logic      [HoldW-1:0]  quot_o,
  output logic                   done_o
);

  localparam int unsigned CntW = $clog2(HoldW);
  localparam logic [CntW-1:0] CntLast = CntW'(HoldW - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SpeedW-1:0] rem_q, rem_d;
  logic [HoldW-1:0]  quo_q, quo_d;
  logic [SpeedW-1:0] div_q, div_d;
  logic              zero_q, zero_d;
  logic [SpeedW:0]   trial;
  logic [SpeedW:0]   diff;
  logic              ge;

  // One quotient bit per cycle by restoring division; the dividend is
  // shifted out of the quotient register as the result bits come in.
  assign trial = {rem_q, quo_q[HoldW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = HoldBase;
      div_d  = divisor_i;
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      rem_d = ge ? diff[SpeedW-1:0] : trial[SpeedW-1:0];
      quo_d = {quo_q[HoldW-2:0], ge};
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    zero_q <= zero_d;
  end

  // A speed of zero saturates the hold time.
  assign quot_o = zero_q ? HoldBase : quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: hdl/sap_dp.sv
`default_nettype none
module sap_dp import sap_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic [KindW-1:0]  kind_i,
  input  wire logic [AngleW-1:0] target_deg_i,
  input  wire logic [SpeedW-1:0] speed_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic      [MaskW-1:0]  coil_mask_o,
  output logic      [HoldW-1:0]  hold_time_o,
  output logic      [MaskW-1:0]  indicator_toggle_o,
  output logic                   last_o
);

  logic [1:0]        phase_q, phase_d;
  logic [AngleW-1:0] pos_q, pos_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [AngleW-1:0] tgt_q, tgt_d;
  logic              up_q, up_d;
  logic [AngleW-1:0] rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [MaskW-1:0]  mask_q, mask_d;
  logic [HoldW-1:0]  hold_q, hold_d;
  logic [MaskW-1:0]  ind_q, ind_d;
  logic              last_q, last_d;

  logic [AngleW-1:0] tgt_in;
  logic              gt;
  logic [AngleW-1:0] raw;
  logic              wrap;
  logic [AngleW-1:0] travel;
  logic              is_single;
  logic              step_up;
  logic [1:0]        ph_next;
  logic              last_step;
  logic [HoldW-1:0]  quot;
  logic              div_done;

  sap_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.cap),
    .divisor_i (speed_i),
    .quot_o    (quot),
    .done_o    (div_done)
  );

  assign tgt_in = (target_deg_i >= FullTurn) ? target_deg_i - FullTurn : target_deg_i;

  // Shortest way round: the direction flips whenever the raw distance wraps.
  assign gt     = tgt_q > pos_q;
  assign raw    = gt ? tgt_q - pos_q : pos_q - tgt_q;
  assign wrap   = raw > HalfTurn;
  assign travel = wrap ? FullTurn - raw : raw;

  assign is_single = (kind_q == KindUp) || (kind_q == KindDown);
  assign step_up   = is_single ? (kind_q == KindUp) : up_q;
  assign ph_next   = phase_q + 2'd1;
  assign last_step = is_single || (rem_q < LastLimit);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    tgt_d       = tgt_q;
    up_d        = up_q;
    rem_d       = rem_q;
    mask_d      = mask_q;
    hold_d      = hold_q;
    ind_d       = ind_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.cap) begin
      kind_d = kind_i;
      tgt_d  = tgt_in;
    end
    if (cmd_i.calc) begin
      up_d  = gt ^ wrap;
      rem_d = {travel[AngleW-2:0], 1'b0};
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      phase_d     = ph_next;
      rem_d       = rem_q - StepDbl;
      mask_d      = step_up ? up_mask(phase_q) : down_mask(ph_next);
      hold_d      = quot;
      ind_d       = (kind_q == KindDown) ? MaskW'(4'b0001 << ph_next) : '0;
      last_d      = last_step;
    end
    if (cmd_i.store) begin
      pos_d = tgt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tgt_q  <= tgt_d;
    up_q   <= up_d;
    rem_q  <= rem_d;
    mask_q <= mask_d;
    hold_q <= hold_d;
    ind_q  <= ind_d;
    last_q <= last_d;
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.has_step  = is_single || ((kind_q == KindMove) && (rem_q >= StepDbl));
  assign sts_o.last_step = last_step;
  assign sts_o.is_move   = (kind_q == KindMove);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign coil_mask_o        = mask_q;
  assign hold_time_o        = hold_q;
  assign indicator_toggle_o = ind_q;
  assign last_o             = last_q;

endmodule
`default_nettype wire

// File: hdl/sap_ctrl.sv
`default_nettype none
module sap_ctrl import sap_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) begin
          if (sts_i.has_step) begin
            state_d = StStep;
          end else begin
            cmd_o.store = sts_i.is_move;
            state_d     = StIdle;
          end
        end
      end
      StStep: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_step) begin
            cmd_o.store = sts_i.is_move;
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule
`default_nettype wire

// File: hdl/stepper_angle_positioner_top.sv
// The first result of a request follows the bit-serial division of 1250 by the speed, with
// the capture and calculation states before it and the handover to the step state after it.
// Further steps of a move follow one per cycle while the output is taken.
// A new request is taken only in the idle state, once the last one is done; a move gives up
// to 24 steps, a single step gives one.
// Reset clears phase, stored angle, state machine and output valid.
`default_nettype none
module stepper_angle_positioner_top import sap_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [KindW-1:0]  kind_i,
  input  wire logic [AngleW-1:0] target_deg_i,
  input  wire logic [SpeedW-1:0] speed_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [MaskW-1:0]  coil_mask_o,
  output logic      [HoldW-1:0]  hold_time_o,
  output logic      [MaskW-1:0]  indicator_toggle_o,
  output logic                   last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sap_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kind_i             (kind_i),
    .target_deg_i       (target_deg_i),
    .speed_i            (speed_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .coil_mask_o        (coil_mask_o),
    .hold_time_o        (hold_time_o),
    .indicator_toggle_o (indicator_toggle_o),
    .last_o             (last_o)
  );

endmodule
`default_nettype wire

// File: hdl/sap_checker.sv
`default_nettype none
`include "stepper_angle_positioner_top_defines.svh"
module sap_checker import sap_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [MaskW-1:0] coil_mask_o,
  input wire logic [HoldW-1:0] hold_time_o,
  input wire logic [MaskW-1:0] indicator_toggle_o,
  input wire logic             last_o
);

  logic        shape_ok;
  logic        in_accept;
  logic        out_stall;
  logic [19:0] payload;

  assign shape_ok  = ((coil_mask_o == 4'h3) || (coil_mask_o == 4'h6) ||
                      (coil_mask_o == 4'hC) || (coil_mask_o == 4'h9)) &&
                     $onehot0(indicator_toggle_o);
  assign in_accept = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign payload   = {coil_mask_o, hold_time_o, indicator_toggle_o, last_o};

  `SAP_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result shown during reset")

  `SAP_ASSERT(a_step_shape, out_valid_o |-> shape_ok, "coil mask or indicator toggle malformed")

  `SAP_ASSERT(a_hold_in_range, out_valid_o |-> (hold_time_o <= HoldBase), "hold time too high")

  `SAP_ASSERT(a_stall_holds, out_stall |=> (out_valid_o && $stable(payload)), "stalled result changed")

  `SAP_ASSERT(a_busy_after_request, in_accept |=> !in_ready_o, "ready held after a request")

endmodule

bind stepper_angle_positioner_top sap_checker u_sap_checker (.*);
`default_nettype wire
